FILE: hw/rtl/wls_pkg.sv
package wls_pkg;

  localparam int VAL_W    = 24;
  localparam int IDX_W    = 11;
  localparam int KIND_W   = 3;
  localparam int CELLS_W  = 11;
  localparam int COEF_W   = 17;
  localparam int STEPS_W  = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_CELLS_DEF = 1024;

  localparam logic [COEF_W-1:0]  COEF_MAX    = 17'd65536;
  localparam logic [CELLS_W-1:0] CELLS_RST   = 11'd1024;
  localparam logic [COEF_W-1:0]  COEF_RST    = 17'd65536;
  localparam logic [STEPS_W-1:0] STEPS_RST   = 16'd308;

  localparam logic [KIND_W-1:0] KIND_WR_P = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_U = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_P = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RD_U = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd2;

  typedef struct packed {
    logic              wr_p;
    logic              wr_u;
    logic              step_p;
    logic              step_u;
    logic              rd_load;
    logic              rd_sel_u;
    logic              rd_shift;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // old + floor(k * (hi - lo) / 2^16), saturated to 24 bits
  function automatic logic [VAL_W-1:0] leap(input logic [VAL_W-1:0] old_v,
                                            input logic [VAL_W-1:0] hi,
                                            input logic [VAL_W-1:0] lo,
                                            input logic [COEF_W-1:0] k);
    logic signed [VAL_W:0]   diff;
    logic signed [COEF_W:0]  k_s;
    logic signed [42:0]      prod;
    logic signed [26:0]      sum;
    diff = $signed({hi[VAL_W-1], hi}) - $signed({lo[VAL_W-1], lo});
    k_s  = $signed({1'b0, k});
    prod = diff * k_s;
    sum  = $signed({{3{old_v[VAL_W-1]}}, old_v}) + $signed(prod[42:16]);
    if (sum > 27'sd8388607) begin
      return 24'h7FFFFF;
    end else if (sum < -27'sd8388608) begin
      return 24'h800000;
    end
    return sum[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/wls_cell.sv
module wls_cell #(
  parameter int IDX = 0,
  parameter int NW  = 11
) (
  input  logic                          clk,
  input  wls_pkg::cmd_t                 cmd,
  input  logic [NW-1:0]                 n_cells,
  input  logic [wls_pkg::COEF_W-1:0]    k,
  input  logic [wls_pkg::VAL_W-1:0]     u_right,
  input  logic [wls_pkg::VAL_W-1:0]     p_left,
  input  logic [wls_pkg::VAL_W-1:0]     rd_right,
  output logic [wls_pkg::VAL_W-1:0]     p,
  output logic [wls_pkg::VAL_W-1:0]     u,
  output logic [wls_pkg::VAL_W-1:0]     rd
);

  logic [wls_pkg::VAL_W-1:0] p_r;
  logic [wls_pkg::VAL_W-1:0] u_r;
  logic [wls_pkg::VAL_W-1:0] rd_r;
  logic                      hit;
  logic                      en_p;
  logic                      en_u;

  assign hit  = (32'(cmd.idx) == IDX);
  assign en_p = (IDX < 32'(n_cells));
  assign en_u = en_p && (IDX >= 1);

  always_ff @(posedge clk) begin
    if (cmd.wr_p && hit) begin
      p_r <= cmd.value;
    end else if (cmd.step_p && en_p) begin
      p_r <= wls_pkg::leap(p_r, u_right, u_r, k);
    end

    if (cmd.wr_u && hit) begin
      u_r <= cmd.value;
    end else if (cmd.step_u && en_u) begin
      u_r <= wls_pkg::leap(u_r, p_r, p_left, k);
    end

    if (cmd.rd_load) begin
      rd_r <= cmd.rd_sel_u ? u_r : p_r;
    end else if (cmd.rd_shift) begin
      rd_r <= rd_right;
    end
  end

  assign p  = p_r;
  assign u  = u_r;
  assign rd = rd_r;

endmodule

FILE: hw/rtl/wave_1d_leapfrog_stepper.sv
// 1D leapfrog wave solver built as a row of MAX_CELLS cells, each holding one
// pressure value and the velocity node at its left edge; the last velocity node
// sits in the top level. Writes go straight into the addressed cell. A read of
// entry i loads the read chain and shifts the value down the cell row to the
// output register. A run updates all active cells at once, pressure then
// velocity in each time step, and then gives the completion item. No item is
// accepted during a read or a run; a finished result waits in the output
// register while the next item is taken.
module wave_1d_leapfrog_stepper #(
  parameter int MAX_CELLS = wls_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wls_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wls_pkg::KIND_W-1:0]         in_kind,
  input  logic [wls_pkg::IDX_W-1:0]          in_index,
  input  logic signed [wls_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wls_pkg::VAL_W-1:0]   out_read_value,
  output logic                               out_run_done
);

  localparam int NW = $clog2(MAX_CELLS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP_P,
    ST_STEP_U,
    ST_FIN
  } state_t;

  state_t                          state_r;
  logic [NW-1:0]                   cnt_r;
  logic [wls_pkg::STEPS_W-1:0]     t_r;
  logic [wls_pkg::VAL_W-1:0]       res_val_r;
  logic                            res_done_r;
  logic                            out_valid_r;
  logic [wls_pkg::VAL_W-1:0]       out_val_r;
  logic                            out_done_r;

  logic [wls_pkg::CELLS_W-1:0]     cell_count_r;
  logic [wls_pkg::COEF_W-1:0]      step_coeff_r;
  logic [wls_pkg::STEPS_W-1:0]     step_count_r;
  logic [wls_pkg::VAL_W-1:0]       ub_r;

  logic                            in_acc;
  logic                            p_ok;
  logic                            u_ok;
  logic [NW-1:0]                   n_use;
  logic [wls_pkg::COEF_W-1:0]      k_use;
  logic                            last_step;
  wls_pkg::cmd_t                   cmd;

  logic [wls_pkg::VAL_W-1:0]       p_w  [MAX_CELLS];
  logic [wls_pkg::VAL_W-1:0]       u_w  [MAX_CELLS];
  logic [wls_pkg::VAL_W-1:0]       rd_w [MAX_CELLS];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign p_ok     = (32'(in_index) < MAX_CELLS);
  assign u_ok     = (32'(in_index) <= MAX_CELLS);

  always_comb begin
    if (cell_count_r < 11'd2) begin
      n_use = NW'(2);
    end else if (32'(cell_count_r) > MAX_CELLS) begin
      n_use = NW'(MAX_CELLS);
    end else begin
      n_use = NW'(cell_count_r);
    end
    k_use = (step_coeff_r > wls_pkg::COEF_MAX) ? wls_pkg::COEF_MAX : step_coeff_r;
  end

  assign last_step = ({1'b0, t_r} + 17'd1) == {1'b0, step_count_r};

  always_comb begin
    cmd.wr_p     = in_acc && (in_kind == wls_pkg::KIND_WR_P) && p_ok;
    cmd.wr_u     = in_acc && (in_kind == wls_pkg::KIND_WR_U) && u_ok;
    cmd.rd_load  = in_acc && (((in_kind == wls_pkg::KIND_RD_P) && p_ok) ||
                              ((in_kind == wls_pkg::KIND_RD_U) && u_ok));
    cmd.rd_sel_u = (in_kind == wls_pkg::KIND_RD_U);
    cmd.rd_shift = (state_r == ST_READ) && (cnt_r != '0);
    cmd.step_p   = (state_r == ST_STEP_P);
    cmd.step_u   = (state_r == ST_STEP_U);
    cmd.idx      = in_index;
    cmd.value    = in_value;
  end

  // rightmost velocity node, fixed during runs
  always_ff @(posedge clk) begin
    if (cmd.wr_u && (32'(in_index) == MAX_CELLS)) begin
      ub_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= wls_pkg::CELLS_RST;
      step_coeff_r <= wls_pkg::COEF_RST;
      step_count_r <= wls_pkg::STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wls_pkg::CFG_CELL_COUNT: cell_count_r <= cfg_data[wls_pkg::CELLS_W-1:0];
        wls_pkg::CFG_STEP_COEFF: step_coeff_r <= cfg_data[wls_pkg::COEF_W-1:0];
        wls_pkg::CFG_STEP_COUNT: step_count_r <= cfg_data[wls_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CELLS; gi++) begin : g_cell
      logic [wls_pkg::VAL_W-1:0] u_right;
      logic [wls_pkg::VAL_W-1:0] p_left;
      logic [wls_pkg::VAL_W-1:0] rd_right;
      if (gi == MAX_CELLS - 1) begin : g_last
        assign u_right  = ub_r;
        assign rd_right = ub_r;
      end else begin : g_mid
        assign u_right  = u_w[gi+1];
        assign rd_right = rd_w[gi+1];
      end
      if (gi == 0) begin : g_first
        assign p_left = '0;
      end else begin : g_rest
        assign p_left = p_w[gi-1];
      end
      wls_cell #(
        .IDX (gi),
        .NW  (NW)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .n_cells  (n_use),
        .k        (k_use),
        .u_right  (u_right),
        .p_left   (p_left),
        .rd_right (rd_right),
        .p        (p_w[gi]),
        .u        (u_w[gi]),
        .rd       (rd_w[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_kind) inside
              wls_pkg::KIND_RUN: begin
                t_r        <= '0;
                res_val_r  <= '0;
                res_done_r <= 1'b1;
                state_r    <= (step_count_r == '0) ? ST_FIN : ST_STEP_P;
              end
              wls_pkg::KIND_RD_P, wls_pkg::KIND_RD_U: begin
                res_done_r <= 1'b0;
                if (cmd.rd_load) begin
                  cnt_r   <= NW'(in_index);
                  state_r <= ST_READ;
                end else begin
                  res_val_r <= '0;
                  state_r   <= ST_FIN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (cnt_r == '0) begin
            res_val_r <= rd_w[0];
            state_r   <= ST_FIN;
          end else begin
            cnt_r <= cnt_r - NW'(1);
          end
        end
        ST_STEP_P: begin
          state_r <= ST_STEP_U;
        end
        ST_STEP_U: begin
          if (last_step) begin
            state_r <= ST_FIN;
          end else begin
            t_r     <= t_r + 16'd1;
            state_r <= ST_STEP_P;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_done_r  <= res_done_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_run_done   = out_done_r;

endmodule

FILE: hw/rtl/wls_checker.sv
module wls_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_we,
  input logic [wls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [wls_pkg::CFG_W-1:0]          cfg_data,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [wls_pkg::KIND_W-1:0]         in_kind,
  input logic [wls_pkg::IDX_W-1:0]          in_index,
  input logic signed [wls_pkg::VAL_W-1:0]   in_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [wls_pkg::VAL_W-1:0]   out_read_value,
  input logic                               out_run_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) &&
                               $stable(out_run_done))
    else $error("result changed while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> out_read_value == '0)
    else $error("run completion carries a nonzero value");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == wls_pkg::KIND_RUN |=> in_stall)
    else $error("input taken right after a run item");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_kind == wls_pkg::KIND_RD_P || in_kind == wls_pkg::KIND_RD_U) |=> in_stall)
    else $error("input taken right after a read item");

endmodule

bind wave_1d_leapfrog_stepper wls_checker u_wls_checker (.*);

FILE: tb/testbench.sv
module testbench;
  import wls_pkg::*;

  localparam int GRID_MAX = MAX_CELLS_DEF;
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd5;
  localparam logic signed [VAL_W-1:0] VAL_TOP = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_BOT = 24'sh800000;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    run_done;
  } grid_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind;
  logic [IDX_W-1:0]         in_index;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_read_value;
  logic                     out_run_done;

  logic signed [VAL_W-1:0] p_grid [0:GRID_MAX-1];
  logic signed [VAL_W-1:0] u_grid [0:GRID_MAX];
  logic [CELLS_W-1:0]      cells_reg;
  logic [COEF_W-1:0]       coef_reg;
  logic [STEPS_W-1:0]      steps_reg;

  grid_result_t grid_results[$];
  grid_result_t want;
  int           fail_count;
  int           rx_hold;
  bit           tx_gaps;
  bit           rx_gaps;

  wave_1d_leapfrog_stepper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_run_done   (out_run_done)
  );

  always #5 clk = ~clk;

  // old + floor(k * (hi - lo) / 2^16), clamped to 24 bits
  function automatic logic signed [VAL_W-1:0] leap_value(input logic signed [VAL_W-1:0] prev,
                                                         input logic signed [VAL_W-1:0] hi,
                                                         input logic signed [VAL_W-1:0] lo,
                                                         input int k);
    longint d;
    longint acc;
    d = longint'(hi) - longint'(lo);
    acc = longint'(prev) + ((d * longint'(k)) >>> 16);
    if (acc > longint'(VAL_TOP)) begin
      acc = longint'(VAL_TOP);
    end else if (acc < longint'(VAL_BOT)) begin
      acc = longint'(VAL_BOT);
    end
    return acc[VAL_W-1:0];
  endfunction

  function automatic int active_cells();
    int c;
    c = cells_reg;
    if (c < 2) begin
      c = 2;
    end else if (c > GRID_MAX) begin
      c = GRID_MAX;
    end
    return c;
  endfunction

  function automatic void advance_grid();
    int n;
    int k;
    n = active_cells();
    k = (coef_reg > COEF_MAX) ? int'(COEF_MAX) : int'(coef_reg);
    for (int t = 0; t < int'(steps_reg); t++) begin
      for (int i = 0; i < n; i++) begin
        p_grid[i] = leap_value(p_grid[i], u_grid[i+1], u_grid[i], k);
      end
      for (int i = 1; i < n; i++) begin
        u_grid[i] = leap_value(u_grid[i], p_grid[i], p_grid[i-1], k);
      end
    end
  endfunction

  function automatic void grid_accept(input logic [KIND_W-1:0] kind,
                                      input logic [IDX_W-1:0] idx,
                                      input logic signed [VAL_W-1:0] val);
    grid_result_t r;
    r.read_value = '0;
    r.run_done = 1'b0;
    case (kind)
      KIND_WR_P: begin
        if (idx < GRID_MAX) p_grid[idx] = val;
      end
      KIND_WR_U: begin
        if (idx <= GRID_MAX) u_grid[idx] = val;
      end
      KIND_RUN: begin
        advance_grid();
        r.run_done = 1'b1;
        grid_results.push_back(r);
      end
      KIND_RD_P: begin
        if (idx < GRID_MAX) r.read_value = p_grid[idx];
        grid_results.push_back(r);
      end
      KIND_RD_U: begin
        if (idx <= GRID_MAX) r.read_value = u_grid[idx];
        grid_results.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] r;
    case ($urandom_range(0, 9))
      0: return VAL_TOP;
      1: return VAL_BOT;
      2, 3, 4, 5: begin
        r = $urandom_range(0, 131071);
        return r - 24'd65536;
      end
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int n);
    case ($urandom_range(0, 19))
      0: return IDX_W'($urandom_range(0, 2047));
      1, 2, 3: return IDX_W'($urandom_range(0, GRID_MAX));
      default: return IDX_W'($urandom_range(0, n + 1));
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grid_accept(kind, idx, val);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (grid_results.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    idle_input();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CELL_COUNT: cells_reg = data[CELLS_W-1:0];
      CFG_STEP_COEFF: coef_reg = data[COEF_W-1:0];
      CFG_STEP_COUNT: steps_reg = data[STEPS_W-1:0];
      default: begin
      end
    endcase
  endtask

  // every entry gets a value before anything reads it
  task automatic test_fill_grid();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int i = 0; i < GRID_MAX; i++) begin
      send_item(KIND_WR_P, IDX_W'(i), pick_value());
    end
    for (int i = 0; i <= GRID_MAX; i++) begin
      send_item(KIND_WR_U, IDX_W'(i), pick_value());
    end
  endtask

  task automatic test_directed_edges();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_item(KIND_WR_P, 0, VAL_TOP);
    send_item(KIND_WR_P, 1, VAL_BOT);
    send_item(KIND_WR_U, 0, VAL_BOT);
    send_item(KIND_WR_U, GRID_MAX, VAL_TOP);
    send_item(KIND_WR_U, 1, '0);
    send_item(KIND_RD_P, 0, '1);
    send_item(KIND_RD_P, 1, '0);
    send_item(KIND_RD_U, 0, '0);
    send_item(KIND_RD_U, GRID_MAX, '0);
    send_item(KIND_RD_P, GRID_MAX - 1, '0);
    // out-of-range indices
    send_item(KIND_WR_P, GRID_MAX, 24'sd5);
    send_item(KIND_RD_P, GRID_MAX, '0);
    send_item(KIND_WR_U, GRID_MAX + 1, 24'sd7);
    send_item(KIND_RD_U, GRID_MAX + 1, '0);
    send_item(KIND_RD_U, '1, '1);
    send_item(KIND_WR_P, '1, VAL_TOP);
    send_item(KIND_RD_P, '1, '0);
    // unused kinds, then runs and reads
    send_item(KIND_SPARE, 3, VAL_TOP);
    send_item(KIND_SPARE + 3'd1, 4, '1);
    send_item(KIND_SPARE + 3'd2, '1, VAL_BOT);
    send_item(KIND_RUN, '1, '1);
    send_item(KIND_RD_P, 0, '0);
    send_item(KIND_RD_U, 1, '0);
    send_item(KIND_RD_U, GRID_MAX, '0);
    settle();
    set_reg(CFG_STEP_COUNT, '0);
    send_item(KIND_RUN, 0, '0);
    send_item(KIND_RD_P, 5, '0);
  endtask

  task automatic test_config_extremes();
    int cells [6] = '{0, 1, 2047, 2, 1024, 1025};
    int coefs [6] = '{131071, 65536, 0, 1, 65535, 65537};
    int steps [6] = '{3, 65535, 2, 1, 5, 1};
    int n;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int s = 0; s < 6; s++) begin
      settle();
      set_reg(CFG_CELL_COUNT, CFG_W'(cells[s]));
      set_reg(CFG_STEP_COEFF, CFG_W'(coefs[s]));
      set_reg(CFG_STEP_COUNT, CFG_W'(steps[s]));
      n = active_cells();
      send_item(KIND_WR_U, 0, pick_value());
      send_item(KIND_RUN, pick_index(n), pick_value());
      send_item(KIND_RD_U, 0, pick_value());
      send_item(KIND_RD_U, IDX_W'(n), pick_value());
      send_item(KIND_RD_P, IDX_W'(n - 1), pick_value());
      send_item(KIND_RD_U, IDX_W'(n - 1), pick_value());
      send_item(KIND_RD_P, IDX_W'(n), pick_value());
      send_item(KIND_RD_P, 0, pick_value());
    end
  endtask

  task automatic test_random_traffic();
    int counted;
    int blk;
    int len;
    int r;
    int n;
    int k;
    logic [KIND_W-1:0] kind;
    counted = 0;
    blk = 0;
    while (counted < 550) begin
      settle();
      r = $urandom_range(0, 19);
      if (r == 0) begin
        n = $urandom_range(0, 1);
      end else if (r < 3) begin
        n = $urandom_range(41, 2047);
      end else begin
        n = $urandom_range(2, 40);
      end
      r = $urandom_range(0, 9);
      if (r < 2) begin
        k = COEF_MAX;
      end else if (r == 2) begin
        k = 0;
      end else if (r == 3) begin
        k = $urandom_range(65537, 131071);
      end else begin
        k = $urandom_range(0, 65536);
      end
      set_reg(CFG_CELL_COUNT, {6'($urandom_range(0, 63)), 11'(n)});
      set_reg(CFG_STEP_COEFF, CFG_W'(k));
      set_reg(CFG_STEP_COUNT, {1'($urandom_range(0, 1)), 16'($urandom_range(0, 10))});
      tx_gaps = (blk % 4 != 1);
      rx_gaps = (blk % 4 != 2);
      n = active_cells();
      len = $urandom_range(15, 35);
      for (int j = 0; j < len; j++) begin
        if ((blk == 0 && j == len / 2) || $urandom_range(0, 40) == 0) begin
          idle_input();
          wait_drained();
        end
        r = $urandom_range(0, 99);
        if (r < 28) begin
          kind = KIND_WR_P;
        end else if (r < 56) begin
          kind = KIND_WR_U;
        end else if (r < 64) begin
          kind = KIND_RUN;
        end else if (r < 80) begin
          kind = KIND_RD_P;
        end else if (r < 96) begin
          kind = KIND_RD_U;
        end else begin
          kind = KIND_SPARE + 3'($urandom_range(0, 2));
        end
        if (kind < KIND_SPARE) counted++;
        send_item(kind, pick_index(n), pick_value());
      end
      blk++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grid_results.size() == 0) begin
        $display("%0t: unexpected result read_value=%0d run_done=%0b", $time,
                 out_read_value, out_run_done);
        fail_count++;
      end else begin
        want = grid_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d got %0d", $time,
                   $signed(want.read_value), out_read_value);
          fail_count++;
        end
        if (out_run_done !== want.run_done) begin
          $display("%0t: run_done expected %0b got %0b", $time, want.run_done, out_run_done);
          fail_count++;
        end
      end
      rx_hold = rx_gaps ? $urandom_range(0, 10) : 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold > 0);
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_index = '0;
    in_value = '0;
    out_stall = 1'b0;
    rx_hold = 0;
    fail_count = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    cells_reg = CELLS_RST;
    coef_reg = COEF_RST;
    steps_reg = STEPS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_grid();
    test_directed_edges();
    test_config_extremes();
    test_random_traffic();
    idle_input();
    wait_drained();
    repeat (2100) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wls_pkg.sv
hw/rtl/wls_cell.sv
hw/rtl/wave_1d_leapfrog_stepper.sv
hw/rtl/wls_checker.sv
tb/testbench.sv
